@@ rtl/tsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants for the SYN/ACK window clamp
// Frame header offsets, protocol codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int WORD_W    = 16;
  localparam int COUNT_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int OFF_W     = 16;
  localparam int TCP_OFF_W = 7;   // 14 + 4*15 + 20 stays below 128

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [OFF_W-1:0]   offset_t;
  typedef logic [TCP_OFF_W-1:0] tcp_off_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_WINDOW = 1'd1;

  localparam word_t SERVER_PORT_RST  = 16'd443;
  localparam word_t CLAMP_WINDOW_RST = 16'd2;

  localparam word_t    ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [3:0] MIN_IHL      = 4'd5;
  localparam word_t    FLAG_SYN       = 16'h0002;
  localparam word_t    FLAG_ACK       = 16'h0010;

  localparam offset_t  OFF_ETHERTYPE  = 16'd12;
  localparam offset_t  OFF_IP_VER_IHL = 16'd14;
  localparam offset_t  OFF_IP_PROTO   = 16'd22;
  localparam offset_t  OFF_MAX        = 16'hfffe;
  localparam tcp_off_t ETH_HDR_BYTES  = 7'd14;
  localparam tcp_off_t TCP_HDR_BYTES  = 7'd20;
  localparam tcp_off_t TCP_FLAGS_OFF  = 7'd12;
  localparam tcp_off_t TCP_WIN_OFF    = 7'd14;
  localparam tcp_off_t TCP_CSUM_OFF   = 7'd16;

  // RFC 1624 incremental update: HC' = ~(~HC + ~m + m')
  function automatic word_t csum_fix(word_t hc, word_t m_old, word_t m_new);
    logic [17:0] s0;
    logic [16:0] s1;
    word_t       s2;
    s0 = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
    s1 = {15'd0, s0[17:16]} + {1'b0, s0[15:0]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    return ~s2;
  endfunction

endpackage

@@ rtl/tcp_synack_window_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// tcp_synack_window_clamp_unit: SYN/ACK window clamp with checksum repair
// Streams an Ethernet frame word by word, rewrites the TCP window of
// matching IPv4 SYN/ACK segments and patches the TCP checksum.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result
// register, before it is offered. Throughput: one item per cycle while the
// result channel does not stall; the header decode and checksum fold sit
// between the two registers and carry no loop.
// Reset (synchronous, rst_n low): both stages empty, frame state and the
// clamp counter cleared, server_port = 443, clamp_window = 2.
module tcp_synack_window_clamp_unit
  import tsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_data_word,
  input  logic                 in_last,
  input  logic [WORD_W-1:0]    in_frame_length,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_word,
  output logic                 out_last,
  output logic                 out_frame_clamped,
  output logic [COUNT_W-1:0]   out_clamp_total
);

  // configuration registers
  word_t server_port_r, clamp_window_r;

  // input stage
  logic  s1_valid_r;
  word_t s1_word_r, s1_flen_r;
  logic  s1_last_r;

  // per-frame state
  offset_t    byte_offset_r, byte_offset_nxt;
  logic [3:0] ihl_r, ihl_nxt;
  logic       tcp_ok_r, tcp_ok_nxt;
  logic       port_match_r, port_match_nxt;
  logic       synack_r, synack_nxt;
  logic       rewrite_r, rewrite_nxt;
  word_t      old_window_r, old_window_nxt;
  count_t     clamp_cnt_r, clamp_cnt_nxt;

  // output stage
  logic   out_valid_r;
  word_t  out_word_r, out_word_nxt;
  logic   out_last_r;
  logic   out_clamped_r;
  count_t out_total_r;

  logic     adv;       // input stage item moves into the result register
  tcp_off_t tcp_base;
  tcp_off_t tcp_need;

  // Advance when the result register is empty or is being drained.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  // Stall only while a held item cannot move on.
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r  <= SERVER_PORT_RST;
      clamp_window_r <= CLAMP_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERVER_PORT:  server_port_r  <= cfg_wdata;
        CFG_CLAMP_WINDOW: clamp_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word_r <= in_data_word;
      s1_last_r <= in_last;
      s1_flen_r <= in_frame_length;
    end
  end

  // Header decode: mirror the offset priority (Ethernet/IP fields first,
  // then the TCP fields relative to the IHL-derived base).
  always_comb begin
    tcp_base        = ETH_HDR_BYTES + {1'b0, ihl_r, 2'b00};
    tcp_need        = ETH_HDR_BYTES + {1'b0, ihl_r, 2'b00} + TCP_HDR_BYTES;

    byte_offset_nxt = byte_offset_r;
    ihl_nxt         = ihl_r;
    tcp_ok_nxt      = tcp_ok_r;
    port_match_nxt  = port_match_r;
    synack_nxt      = synack_r;
    rewrite_nxt     = rewrite_r;
    old_window_nxt  = old_window_r;
    clamp_cnt_nxt   = clamp_cnt_r;
    out_word_nxt    = s1_word_r;

    if (byte_offset_r == OFF_ETHERTYPE) begin
      tcp_ok_nxt = (s1_word_r == ETHERTYPE_IPV4);
    end else if (byte_offset_r == OFF_IP_VER_IHL) begin
      ihl_nxt = s1_word_r[11:8];
      if (s1_word_r[11:8] < MIN_IHL) begin
        tcp_ok_nxt = 1'b0;
      end
    end else if (byte_offset_r == OFF_IP_PROTO) begin
      if (s1_word_r[7:0] != PROTO_TCP ||
          s1_flen_r < {{(OFF_W-TCP_OFF_W){1'b0}}, tcp_need}) begin
        tcp_ok_nxt = 1'b0;
      end
    end else if (tcp_ok_r &&
                 byte_offset_r == {{(OFF_W-TCP_OFF_W){1'b0}}, tcp_base}) begin
      port_match_nxt = (s1_word_r == server_port_r);
    end else if (tcp_ok_r && byte_offset_r ==
                 {{(OFF_W-TCP_OFF_W){1'b0}}, tcp_base + TCP_FLAGS_OFF}) begin
      synack_nxt = ((s1_word_r & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK));
    end else if (tcp_ok_r && byte_offset_r ==
                 {{(OFF_W-TCP_OFF_W){1'b0}}, tcp_base + TCP_WIN_OFF}) begin
      if (port_match_r && synack_r) begin
        rewrite_nxt    = 1'b1;
        old_window_nxt = s1_word_r;
        out_word_nxt   = clamp_window_r;
        clamp_cnt_nxt  = clamp_cnt_r + 64'd1;
      end
    end else if (tcp_ok_r && byte_offset_r ==
                 {{(OFF_W-TCP_OFF_W){1'b0}}, tcp_base + TCP_CSUM_OFF}) begin
      if (rewrite_r) begin
        out_word_nxt = csum_fix(s1_word_r, old_window_r, clamp_window_r);
      end
    end

    // Drop all frame state on the final word; otherwise advance the offset.
    if (s1_last_r) begin
      byte_offset_nxt = '0;
      ihl_nxt         = '0;
      tcp_ok_nxt      = 1'b0;
      port_match_nxt  = 1'b0;
      synack_nxt      = 1'b0;
      rewrite_nxt     = 1'b0;
      old_window_nxt  = '0;
    end else if (byte_offset_r < OFF_MAX) begin
      byte_offset_nxt = byte_offset_r + 16'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      ihl_r         <= '0;
      tcp_ok_r      <= 1'b0;
      port_match_r  <= 1'b0;
      synack_r      <= 1'b0;
      rewrite_r     <= 1'b0;
      old_window_r  <= '0;
      clamp_cnt_r   <= '0;
    end else if (adv) begin
      byte_offset_r <= byte_offset_nxt;
      ihl_r         <= ihl_nxt;
      tcp_ok_r      <= tcp_ok_nxt;
      port_match_r  <= port_match_nxt;
      synack_r      <= synack_nxt;
      rewrite_r     <= rewrite_nxt;
      old_window_r  <= old_window_nxt;
      clamp_cnt_r   <= clamp_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r    <= out_word_nxt;
      out_last_r    <= s1_last_r;
      // clamped flag reflects the rewrite decision including this word
      out_clamped_r <= s1_last_r && (rewrite_r ||
                       (clamp_cnt_nxt != clamp_cnt_r));
      out_total_r   <= clamp_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word          = out_word_r;
  assign out_last          = out_last_r;
  assign out_frame_clamped = out_clamped_r;
  assign out_clamp_total   = out_total_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clamp_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_clamped |-> out_last)
    else $error("frame_clamped raised on a word that is not the last");

  a_offset_even : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> !byte_offset_r[0])
    else $error("byte offset became odd");

  a_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(clamp_cnt_r))
    else $error("clamp counter moved without an item");

  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame-level check of the SYN/ACK window clamp
// Streams directed and random Ethernet frames through the block, with both
// sides idling at random. A scoreboard predicts every output word and
// compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tsw_pkg::*;

  // Header byte positions seen by the predictor and the frame builder
  localparam int ETYPE_AT   = 12;
  localparam int IHL_AT     = 14;
  localparam int PROTO_AT   = 22;
  localparam int ETH_BYTES  = 14;
  localparam int TCPH_BYTES = 20;
  localparam int FLAGS_REL  = 12;
  localparam int WIN_REL    = 14;
  localparam int CSUM_REL   = 16;
  localparam int POS_CAP    = 16'hfffe;

  // Run shaping
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int PHASE_WORDS      = 200;
  localparam int LONG_FRAME_WORDS = 64;

  typedef struct {
    word_t  word;
    logic   last;
    logic   clamped;
    count_t total;
  } out_item_t;

  // Scoreboard: tracks the frame parser state, the clamp registers and the
  // queue of expected output words.
  class clamp_scoreboard;
    word_t      port_reg;
    word_t      window_reg;
    offset_t    pos;
    logic [3:0] ihl;
    bit         tcp_ok;
    bit         port_hit;
    bit         synack;
    bit         rewriting;
    word_t      saved_window;
    count_t     clamp_cnt;
    out_item_t  pending[$];
    int         errors;

    function new();
      port_reg   = SERVER_PORT_RST;
      window_reg = CLAMP_WINDOW_RST;
      clamp_cnt  = '0;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos          = '0;
      ihl          = '0;
      tcp_ok       = 1'b0;
      port_hit     = 1'b0;
      synack       = 1'b0;
      rewriting    = 1'b0;
      saved_window = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
      case (idx)
        CFG_SERVER_PORT:  port_reg   = value;
        CFG_CLAMP_WINDOW: window_reg = value;
        default: ;
      endcase
    endfunction

    // Ones' complement patch: ~(~hc + ~was + now)
    function word_t ones_patch(word_t hc, word_t was, word_t now);
      logic [31:0] s;
      s = {16'd0, ~hc} + {16'd0, ~was} + {16'd0, now};
      s = (s >> 16) + (s & 32'hffff);
      s = s + (s >> 16);
      return ~s[15:0];
    endfunction

    function void note_input(word_t w, logic last, word_t flen);
      int        tcp_at;
      int        need;
      out_item_t r;
      tcp_at = ETH_BYTES + 4 * ihl;
      r.word = w;
      if (pos == ETYPE_AT) begin
        tcp_ok = (w == ETHERTYPE_IPV4);
      end else if (pos == IHL_AT) begin
        ihl = w[11:8];
        if (ihl < MIN_IHL) tcp_ok = 1'b0;
      end else if (pos == PROTO_AT) begin
        need = ETH_BYTES + 4 * ihl + TCPH_BYTES;
        if (w[7:0] != PROTO_TCP || flen < need) tcp_ok = 1'b0;
      end else if (tcp_ok && pos == tcp_at) begin
        port_hit = (w == port_reg);
      end else if (tcp_ok && pos == tcp_at + FLAGS_REL) begin
        synack = (w & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK);
      end else if (tcp_ok && pos == tcp_at + WIN_REL) begin
        if (port_hit && synack) begin
          rewriting    = 1'b1;
          saved_window = w;
          r.word       = window_reg;
          clamp_cnt    = clamp_cnt + 1'b1;
        end
      end else if (tcp_ok && pos == tcp_at + CSUM_REL) begin
        if (rewriting) r.word = ones_patch(w, saved_window, window_reg);
      end
      r.last    = last;
      r.clamped = last && rewriting;
      r.total   = clamp_cnt;
      if (last) clear_frame();
      else if (pos < POS_CAP) pos = pos + 16'd2;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 100)
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_result(word_t w, logic last, logic clamped, count_t total);
      out_item_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 64'(w), 64'd0);
      end else begin
        e = pending.pop_front();
        if (w !== e.word) report("out_word", 64'(w), 64'(e.word));
        if (last !== e.last) report("out_last", 64'(last), 64'(e.last));
        if (clamped !== e.clamped)
          report("out_frame_clamped", 64'(clamped), 64'(e.clamped));
        if (total !== e.total) report("out_clamp_total", total, e.total);
      end
    endtask
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_SERVER_PORT;
  logic [WORD_W-1:0]    cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic [WORD_W-1:0]    in_data_word    = '0;
  logic                 in_last         = 1'b0;
  logic [WORD_W-1:0]    in_frame_length = '0;
  logic                 out_stall       = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_word;
  logic                 out_last;
  logic                 out_frame_clamped;
  logic [COUNT_W-1:0]   out_clamp_total;

  clamp_scoreboard sb = new();

  word_t frame_q[$];
  int    words_sent      = 0;
  int    sender_idle_pct = 0;
  int    recv_stall_pct  = 0;
  bit    receiver_hold   = 1'b0;
  int    quiet_cycles    = 0;

  // Idling mode per phase: none, sender only, receiver only, both lightly
  int idle_tab[4]  = '{0, 49, 0, 12};
  int stall_tab[4] = '{0, 0, 49, 12};

  tcp_synack_window_clamp_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_word      (in_data_word),
    .in_last           (in_last),
    .in_frame_length   (in_frame_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word          (out_word),
    .out_last          (out_last),
    .out_frame_clamped (out_frame_clamped),
    .out_clamp_total   (out_clamp_total)
  );

  // 12 ns clock, rising at 6 ns
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off completely while a long
  // hold-off is running. Change only on the falling edge.
  always @(negedge clk) begin
    out_stall <= receiver_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Check every accepted output word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_word, out_last, out_frame_clamped, out_clamp_total);
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Drop a header word into the frame if the frame reaches that far
  function automatic void place(int at, word_t v);
    if (at / 2 < frame_q.size()) frame_q[at / 2] = v;
  endfunction

  // Fill frame_q with random words, then lay the IPv4/TCP header fields over
  // them. The IP version nibble stays random since the block ignores it.
  function automatic void build_frame(word_t etype, logic [3:0] ihl, logic [7:0] proto,
                                      word_t sport, logic syn, logic ack, int nw);
    int    tcp_at;
    word_t flags;
    frame_q.delete();
    repeat (nw) frame_q.push_back(word_t'($urandom));
    tcp_at = ETH_BYTES + 4 * ihl;
    flags  = word_t'($urandom);
    flags  = syn ? (flags | FLAG_SYN) : (flags & ~FLAG_SYN);
    flags  = ack ? (flags | FLAG_ACK) : (flags & ~FLAG_ACK);
    place(ETYPE_AT, etype);
    place(IHL_AT, {4'($urandom), ihl, 8'($urandom)});
    place(PROTO_AT, {8'($urandom), proto});
    place(tcp_at, sport);
    place(tcp_at + FLAGS_REL, flags);
  endfunction

  // Offer one item, idling first at random; wait for acceptance at the
  // rising edge, then return on the next falling edge.
  task automatic send_word(word_t w, logic last, word_t flen);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_word    <= w;
    in_last         <= last;
    in_frame_length <= flen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w, last, flen);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(word_t flen);
    foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1, flen);
  endtask

  // Wait until every predicted word has come out, then let the pipeline settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers back to back; only called with the block idle
  task automatic set_registers(word_t port, word_t win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SERVER_PORT;
    cfg_wdata <= port;
    @(posedge clk);
    sb.write_reg(CFG_SERVER_PORT, port);
    @(negedge clk);
    cfg_index <= CFG_CLAMP_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    sb.write_reg(CFG_CLAMP_WINDOW, win);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed TCP segments aimed at the configured port, so the
  // parser gets deep; the rest are truncated, short or broken frames and noise.
  task automatic send_random_frame();
    int    kind;
    int    ihl;
    int    hdr_words;
    int    nw;
    word_t flen;
    word_t sport;
    logic  syn;
    logic  ack;
    kind      = $urandom_range(99);
    ihl       = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
    hdr_words = 17 + 2 * ihl;
    sport     = ($urandom_range(99) < 70) ? sb.port_reg : word_t'($urandom);
    if ($urandom_range(99) < 65) begin
      syn = 1'b1;
      ack = 1'b1;
    end else begin
      syn = 1'($urandom_range(1));
      ack = 1'($urandom_range(1));
    end
    nw   = hdr_words + $urandom_range(12);
    flen = word_t'(2 * nw - $urandom_range(1));
    if (kind < 62) begin
      build_frame(ETHERTYPE_IPV4, 4'(ihl), PROTO_TCP, sport, syn, ack, nw);
    end else if (kind < 72) begin
      // end the frame early, mostly around the flags, window and checksum
      nw = $urandom_range(1) ? $urandom_range(hdr_words - 1, hdr_words - 4)
                             : $urandom_range(hdr_words - 1, 1);
      build_frame(ETHERTYPE_IPV4, 4'(ihl), PROTO_TCP, sport, syn, ack, nw);
    end else if (kind < 80) begin
      // stated length a few bytes short of the full TCP header
      build_frame(ETHERTYPE_IPV4, 4'(ihl), PROTO_TCP, sport, syn, ack, nw);
      flen = word_t'(2 * hdr_words - $urandom_range(4, 1));
    end else if (kind < 90) begin
      // damaged IPv4 header: odd type, any IHL, other protocol
      build_frame($urandom_range(1) ? word_t'($urandom) : ETHERTYPE_IPV4, 4'($urandom),
                  $urandom_range(1) ? 8'($urandom) : PROTO_TCP, sport, syn, ack, nw);
    end else begin
      nw   = $urandom_range(40, 1);
      flen = word_t'($urandom);
      build_frame(word_t'($urandom), 4'($urandom), 8'($urandom), word_t'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)), nw);
    end
    send_frame(flen);
  endtask

  initial begin
    int start;
    int mode;

    // hold reset for some rising edges, release on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames with the reset registers (port 443, window 2)
    // matching SYN/ACK, minimum IHL, window all ones, checksum zero
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 27);
    place(48, 16'hffff);
    place(50, 16'h0000);
    send_frame(16'd54);
    // largest IHL with options, window zero, checksum all ones
    build_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd443, 1'b1, 1'b1, 49);
    place(88, 16'h0000);
    place(90, 16'hffff);
    send_frame(16'd98);
    // IHL below minimum, wrong type, wrong protocol: pass untouched
    build_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 16'd443, 1'b1, 1'b1, 27);
    send_frame(16'd54);
    build_frame(16'h86dd, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 27);
    send_frame(16'd54);
    build_frame(ETHERTYPE_IPV4, 4'd5, 8'd17, 16'd443, 1'b1, 1'b1, 27);
    send_frame(16'd54);
    // length one byte short of the TCP header, then exactly enough
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 27);
    send_frame(16'd53);
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 30);
    send_frame(16'd54);
    // other port, SYN alone, ACK alone
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd444, 1'b1, 1'b1, 27);
    send_frame(16'd54);
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b0, 27);
    send_frame(16'd54);
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b0, 1'b1, 27);
    send_frame(16'd54);
    // frame ends on the flags word: nothing rewritten
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 24);
    send_frame(16'd54);
    // frame ends on the window word: clamped and counted, checksum never seen
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 25);
    send_frame(16'd54);
    // single-word frame
    build_frame(word_t'($urandom), 4'd5, PROTO_TCP, 16'd443, 1'b1, 1'b1, 1);
    send_frame(16'hffff);
    in_valid <= 1'b0;
    drain();

    // Random phases: rotate the idling mode and the register settings,
    // extremes first.
    for (int p = 1; p <= 7; p++) begin
      mode            = p % 4;
      sender_idle_pct = idle_tab[mode];
      recv_stall_pct  = stall_tab[mode];
      case (p)
        1: set_registers(16'h0000, 16'h0000);
        2: set_registers(16'hffff, 16'hffff);
        4: set_registers(16'h0001, 16'hfffe);
        default: set_registers(word_t'($urandom), word_t'($urandom));
      endcase
      // Phase 4 runs with a free-running sender: hold the receiver off
      // long enough for the pipeline to fill and stall its input.
      if (p == 4) begin
        fork
          begin
            @(posedge clk);
            receiver_hold = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            receiver_hold = 1'b0;
          end
        join_none
      end
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) send_random_frame();
      in_valid <= 1'b0;
      drain();
    end

    // One long matching frame with a payload well past the header:
    // nothing after the checksum word may be touched.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    set_registers(SERVER_PORT_RST, word_t'($urandom));
    build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SERVER_PORT_RST, 1'b1, 1'b1,
                LONG_FRAME_WORDS);
    send_frame(16'hffff);
    in_valid <= 1'b0;
    drain();

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
